@@ rtl/wdm_pkg.sv @@
// ---------------------------------------------------------------------------
// wdm_pkg
// Shared widths, limits and sequencer states for the weighted distance
// moments block (weighted mean and standard deviation of hit distances).
// ---------------------------------------------------------------------------
package wdm_pkg;

  // field widths
  localparam int DIST_W   = 24;
  localparam int WEIGHT_W = 17;

  // accumulator widths
  localparam int WT_W  = 25;
  localparam int ACC_W = 48;
  localparam int WD_W  = 40;

  // shared multiplier
  localparam int MUL_W  = 24;
  localparam int PROD_W = 2 * MUL_W;
  localparam int HALF_W = WD_W / 2;
  localparam int PART_W = HALF_W + DIST_W;

  // shared divider
  localparam int DIV_NUM_W = 57;
  localparam int DIV_DEN_W = WT_W;
  localparam int DIV_CNT_W = 6;

  // square root unit
  localparam int SQ_RAD_W  = 58;
  localparam int SQ_ITER   = SQ_RAD_W / 2;
  localparam int SQ_ROOT_W = SQ_ITER;
  localparam int SQ_RES_W  = SQ_ROOT_W + 1;
  localparam int SQ_REM_W  = 32;
  localparam int SQ_CNT_W  = 5;

  // limits
  localparam logic [DIST_W-1:0]   DIST_MAX   = 24'd16769024;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_WD,
    S_LO,
    S_HI,
    S_RND,
    S_ACC,
    S_CHK,
    S_DIVM,
    S_DIVS,
    S_SQ,
    S_SQRT,
    S_DONE
  } state_t;

endpackage

@@ rtl/wdm_mul.sv @@
// ---------------------------------------------------------------------------
// wdm_mul
// Shared unsigned 24x24 multiplier with a registered product, used for the
// sample products and for squaring the mean.
// ---------------------------------------------------------------------------
module wdm_mul (
  input  logic                         clk,
  input  logic [wdm_pkg::MUL_W-1:0]    a,
  input  logic [wdm_pkg::MUL_W-1:0]    b,
  output logic [wdm_pkg::PROD_W-1:0]   p
);
  import wdm_pkg::*;

  logic [PROD_W-1:0] p_r;

  // one product per cycle
  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign p = p_r;

endmodule

@@ rtl/wdm_div.sv @@
// ---------------------------------------------------------------------------
// wdm_div
// Restoring divider, one quotient bit per cycle. Shared by the mean and the
// mean-square divisions.
// ---------------------------------------------------------------------------
module wdm_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [wdm_pkg::DIV_NUM_W-1:0]  num,
  input  logic [wdm_pkg::DIV_DEN_W-1:0]  den,
  output logic                           done,
  output logic [wdm_pkg::DIV_NUM_W-1:0]  quot
);
  import wdm_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  // one trial subtraction
  assign shifted = {rem_r, num_r[DIV_NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};

  // step control, quotient bits shift into the numerator register
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_NUM_W-2:0], fits};
      rem_nxt = fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

@@ rtl/wdm_sqrt.sv @@
// ---------------------------------------------------------------------------
// wdm_sqrt
// Digit-by-digit integer square root, one root bit per cycle, followed by a
// round-to-nearest step.
// ---------------------------------------------------------------------------
module wdm_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wdm_pkg::SQ_RAD_W-1:0]  radicand,
  output logic                          done,
  output logic [wdm_pkg::SQ_RES_W-1:0]  root
);
  import wdm_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [SQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SQ_RAD_W-1:0]  rad_r, rad_nxt;
  logic [SQ_REM_W-1:0]  rem_r, rem_nxt;
  logic [SQ_ROOT_W-1:0] root_r, root_nxt;
  logic [SQ_RES_W-1:0]  res_r, res_nxt;
  logic [SQ_REM_W+1:0]  shifted;
  logic [SQ_REM_W+1:0]  trial;
  logic                 fits;

  // bring down two radicand bits, try root*4+1
  assign shifted = {rem_r, rad_r[SQ_RAD_W-1 -: 2]};
  assign trial   = (SQ_REM_W+2)'({root_r, 2'b01});
  assign fits    = shifted >= trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    res_nxt  = res_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      if (cnt_r == SQ_CNT_W'(SQ_ITER)) begin
        // round to nearest: remainder above root means past the midpoint
        res_nxt  = ((SQ_REM_W+1)'(rem_r) > (SQ_REM_W+1)'(root_r)) ?
                   SQ_RES_W'(root_r) + 1'b1 : SQ_RES_W'(root_r);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        rad_nxt  = {rad_r[SQ_RAD_W-3:0], 2'b00};
        rem_nxt  = fits ? SQ_REM_W'(shifted - trial) : SQ_REM_W'(shifted);
        root_nxt = {root_r[SQ_ROOT_W-2:0], fits};
        cnt_nxt  = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign root = res_r;

endmodule

@@ rtl/weighted_distance_moments_top.sv @@
// ---------------------------------------------------------------------------
// weighted_distance_moments_top
// Weighted mean and standard deviation of hit distances over one texel run.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall    distance, missed, weight, last
//   out_     output     out_valid / out_stall  mean_distance, deviation,
//                                              no_weight
//
// Between accepts a sample steps through S_WD, S_LO, S_HI, S_RND and S_ACC:
// three passes through the shared 24x24 multiplier, a rounding add and the
// saturating sums. A last sample with nonzero summed weight adds two 57-step
// divisions in the divider, a squaring in the multiplier and a square root.
// Reset clears the sums, the sequencer and the output valid.
// A finished result waits in the output register; a new run is accepted
// meanwhile, and only the next result waits for out_stall to drop.
// ---------------------------------------------------------------------------
module weighted_distance_moments_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wdm_pkg::DIST_W-1:0]     in_distance,
  input  logic                           in_missed,
  input  logic [wdm_pkg::WEIGHT_W-1:0]   in_weight,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wdm_pkg::DIST_W-1:0]     out_mean_distance,
  output logic [wdm_pkg::DIST_W-1:0]     out_deviation,
  output logic                           out_no_weight
);
  import wdm_pkg::*;

  state_t state_r, state_nxt;

  // sample registers
  logic [DIST_W-1:0]   d_r, d_nxt;
  logic [WEIGHT_W-1:0] w_r, w_nxt;
  logic                missed_r, missed_nxt;
  logic                last_r, last_nxt;
  logic [WD_W-1:0]     wd_r, wd_nxt;
  logic [PART_W-1:0]   lo_r, lo_nxt;
  logic [WD_W-1:0]     wdd_r, wdd_nxt;

  // running sums
  logic [WT_W-1:0]  wt_r, wt_nxt;
  logic [ACC_W-1:0] dt_r, dt_nxt;
  logic [ACC_W-1:0] st_r, st_nxt;

  // result path
  logic [DIST_W-1:0]    mean_r, mean_nxt;
  logic [DIV_NUM_W-1:0] msq_r, msq_nxt;
  logic [DIST_W-1:0]    dev_r, dev_nxt;
  logic                 empty_r, empty_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_mean_r, out_mean_nxt;
  logic [DIST_W-1:0] out_dev_r, out_dev_nxt;
  logic              out_empty_r, out_empty_nxt;

  // shared units
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic                 sq_start, sq_done;
  logic [SQ_RAD_W-1:0]  sq_rad;
  logic [SQ_RES_W-1:0]  sq_root;

  // datapath helpers
  logic                 in_take;
  logic                 out_load;
  logic [WD_W+DIST_W:0] sq_sum;
  logic [WT_W:0]        wt_sum;
  logic [ACC_W:0]       dt_sum;
  logic [ACC_W:0]       st_sum;
  logic [DIV_NUM_W-1:0] half_wt;
  logic [DIV_NUM_W-1:0] mean_sq;
  logic [DIV_NUM_W-1:0] variance;

  wdm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  wdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (wt_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  wdm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign in_take  = in_valid && (state_r == S_IDLE);
  assign out_load = !out_valid_r || !out_stall;

  // w*d*d rounded to 8 fraction bits: hi and lo partial products recombined
  assign sq_sum = (WD_W+DIST_W+1)'({mul_p[PART_W-1:0], {HALF_W{1'b0}}})
                + (WD_W+DIST_W+1)'(lo_r)
                + ((WD_W+DIST_W+1)'(1) << (DIST_W - 1));

  // saturating sums, each limit is all ones
  assign wt_sum = {1'b0, wt_r} + (WT_W+1)'(w_r);
  assign dt_sum = {1'b0, dt_r} + (ACC_W+1)'(wd_r);
  assign st_sum = {1'b0, st_r} + (ACC_W+1)'(wdd_r);

  // division and variance operands
  assign half_wt  = DIV_NUM_W'(wt_r[WT_W-1:1]);
  assign mean_sq  = DIV_NUM_W'(mul_p);
  assign variance = (msq_r > mean_sq) ? msq_r - mean_sq : '0;
  assign sq_rad   = SQ_RAD_W'(variance);

  // sequencer, operand selection and register updates
  always_comb begin
    state_nxt     = state_r;
    d_nxt         = d_r;
    w_nxt         = w_r;
    missed_nxt    = missed_r;
    last_nxt      = last_r;
    wd_nxt        = wd_r;
    lo_nxt        = lo_r;
    wdd_nxt       = wdd_r;
    wt_nxt        = wt_r;
    dt_nxt        = dt_r;
    st_nxt        = st_r;
    mean_nxt      = mean_r;
    msq_nxt       = msq_r;
    dev_nxt       = dev_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_mean_nxt  = out_mean_r;
    out_dev_nxt   = out_dev_r;
    out_empty_nxt = out_empty_r;
    mul_a         = mean_r;
    mul_b         = mean_r;
    div_start     = 1'b0;
    div_num       = (DIV_NUM_W'(dt_r)) + half_wt;
    sq_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          d_nxt      = (in_distance > DIST_MAX) ? DIST_MAX : in_distance;
          w_nxt      = (in_weight > WEIGHT_ONE) ? WEIGHT_ONE : in_weight;
          missed_nxt = in_missed;
          last_nxt   = in_last;
          state_nxt  = S_WD;
        end
      end
      S_WD: begin
        mul_a     = MUL_W'(w_r);
        mul_b     = d_r;
        state_nxt = S_LO;
      end
      S_LO: begin
        wd_nxt    = mul_p[WD_W-1:0];
        mul_a     = MUL_W'(mul_p[HALF_W-1:0]);
        mul_b     = d_r;
        state_nxt = S_HI;
      end
      S_HI: begin
        lo_nxt    = mul_p[PART_W-1:0];
        mul_a     = MUL_W'(wd_r[WD_W-1:HALF_W]);
        mul_b     = d_r;
        state_nxt = S_RND;
      end
      S_RND: begin
        wdd_nxt   = sq_sum[WD_W+DIST_W-1:DIST_W];
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (!missed_r) begin
          wt_nxt = wt_sum[WT_W] ? '1 : wt_sum[WT_W-1:0];
          dt_nxt = dt_sum[ACC_W] ? '1 : dt_sum[ACC_W-1:0];
          st_nxt = st_sum[ACC_W] ? '1 : st_sum[ACC_W-1:0];
        end
        state_nxt = last_r ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        if (wt_r == '0) begin
          // empty run: far distance, no spread
          mean_nxt  = DIST_MAX;
          dev_nxt   = '0;
          empty_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          empty_nxt = 1'b0;
          div_start = 1'b1;
          state_nxt = S_DIVM;
        end
      end
      S_DIVM: begin
        if (div_done) begin
          mean_nxt  = (div_quot > DIV_NUM_W'(DIST_MAX)) ?
                      DIST_MAX : div_quot[DIST_W-1:0];
          div_num   = {st_r, 8'h00} + half_wt;
          div_start = 1'b1;
          state_nxt = S_DIVS;
        end
      end
      S_DIVS: begin
        // multiplier squares the mean while the divider runs
        if (div_done) begin
          msq_nxt   = div_quot;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        sq_start  = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sq_done) begin
          dev_nxt   = (sq_root > SQ_RES_W'(DIST_MAX)) ?
                      DIST_MAX : sq_root[DIST_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = mean_r;
          out_dev_nxt   = dev_r;
          out_empty_nxt = empty_r;
          wt_nxt        = '0;
          dt_nxt        = '0;
          st_nxt        = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wt_r        <= '0;
      dt_r        <= '0;
      st_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wt_r        <= wt_nxt;
      dt_r        <= dt_nxt;
      st_r        <= st_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    d_r         <= d_nxt;
    w_r         <= w_nxt;
    missed_r    <= missed_nxt;
    last_r      <= last_nxt;
    wd_r        <= wd_nxt;
    lo_r        <= lo_nxt;
    wdd_r       <= wdd_nxt;
    mean_r      <= mean_nxt;
    msq_r       <= msq_nxt;
    dev_r       <= dev_nxt;
    empty_r     <= empty_nxt;
    out_mean_r  <= out_mean_nxt;
    out_dev_r   <= out_dev_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_mean_distance = out_mean_r;
  assign out_deviation     = out_dev_r;
  assign out_no_weight     = out_empty_r;

  // an empty run always reports the far distance and no spread
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_weight |-> out_mean_distance == DIST_MAX && out_deviation == '0)
    else $error("empty run result is not far distance with zero deviation");

  // results stay within the saturation limit
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mean_distance <= DIST_MAX && out_deviation <= DIST_MAX)
    else $error("result above saturation limit");

  // sums are cleared once a result has been handed to the output register
  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_load |=> wt_r == '0 && dt_r == '0 && st_r == '0)
    else $error("sums not cleared after result");

  // the square root only starts when the divider has finished
  a_sqrt_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> $past(state_r) == S_DIVS && $past(div_done))
    else $error("square root started before mean square was ready");

endmodule
